@@ rtl/tie_pkg.sv @@
// ============================================================================
// tie_pkg : shared types and constants of the instruction executor
// Opcodes, field widths, stream packing sizes, the register file write
// port structure and the is_branch opcode test.
// ============================================================================
package tie_pkg;

   localparam int XLEN        = 32;
   localparam int REG_IDX_W   = 5;
   localparam int REG_COUNT   = 32;
   localparam int OPC_W       = 6;
   localparam int LEN_W       = 16;
   localparam int MADDR_W     = 10;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 120;

   localparam logic [OPC_W-1:0] OPC_ADD  = 6'd1;
   localparam logic [OPC_W-1:0] OPC_SUB  = 6'd2;
   localparam logic [OPC_W-1:0] OPC_ADDI = 6'd17;
   localparam logic [OPC_W-1:0] OPC_BNE  = 6'd18;
   localparam logic [OPC_W-1:0] OPC_BEQ  = 6'd19;
   localparam logic [OPC_W-1:0] OPC_BGT  = 6'd20;
   localparam logic [OPC_W-1:0] OPC_BGE  = 6'd21;
   localparam logic [OPC_W-1:0] OPC_JMP  = 6'd33;
   localparam logic [OPC_W-1:0] OPC_LD   = 6'd49;
   localparam logic [OPC_W-1:0] OPC_ST   = 6'd50;

   localparam logic OP_EXEC    = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [XLEN-1:0]      data;
   } rf_wr_type;

   function automatic logic is_branch(input logic [OPC_W-1:0] opc);
      is_branch = (opc == OPC_BNE) || (opc == OPC_BEQ) ||
                  (opc == OPC_BGT) || (opc == OPC_BGE);
   endfunction

endpackage

@@ rtl/tie_regfile.sv @@
// ============================================================================
// tie_regfile : general register file, two registered read ports
// 32 x 32 memory with one write port. Per-entry valid bits give the zero
// reset value; a write landing on the read edge is forwarded.
// ============================================================================
module tie_regfile
   import tie_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [REG_IDX_W-1:0] rd_idx_a,
   input  logic [REG_IDX_W-1:0] rd_idx_b,
   output logic [XLEN-1:0]      rd_data_a,
   output logic [XLEN-1:0]      rd_data_b,
   input  rf_wr_type            wr
);

   logic [XLEN-1:0]      regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;

   logic [XLEN-1:0] q_a_ff, q_b_ff;
   logic [XLEN-1:0] byp_ff;
   logic            hit_a_ff, hit_b_ff, hit_a_in, hit_b_in;
   logic            qv_a_ff, qv_b_ff, qv_a_in, qv_b_in;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.idx] = 1'b1;
      end
   end

   assign hit_a_in = wr.en && (wr.idx == rd_idx_a);
   assign hit_b_in = wr.en && (wr.idx == rd_idx_b);
   assign qv_a_in  = vld_ff[rd_idx_a];
   assign qv_b_in  = vld_ff[rd_idx_b];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         q_a_ff <= regs_ff[rd_idx_a];
         q_b_ff <= regs_ff[rd_idx_b];
         byp_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
         qv_a_ff  <= 1'b0;
         qv_b_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            hit_a_ff <= hit_a_in;
            hit_b_ff <= hit_b_in;
            qv_a_ff  <= qv_a_in;
            qv_b_ff  <= qv_b_in;
         end
      end
   end

   assign rd_data_a = hit_a_ff ? byp_ff : (qv_a_ff ? q_a_ff : '0);
   assign rd_data_b = hit_b_ff ? byp_ff : (qv_b_ff ? q_b_ff : '0);

endmodule

@@ rtl/tie_dmem.sv @@
// ============================================================================
// tie_dmem : data memory with registered read and reset clearing sweep
// One write and one read port; after reset every word is zeroed, one per
// cycle, while busy is high.
// ============================================================================
module tie_dmem
   import tie_pkg::*;
#(
   parameter int MEM_WORDS = 1024,
   parameter int AW        = 10
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [XLEN-1:0] rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [XLEN-1:0] wr_data,
   output logic            busy
);

   logic [XLEN-1:0] mem_ff [MEM_WORDS];
   logic [XLEN-1:0] q_ff;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic            clr_busy_ff, clr_busy_in;
   logic            we;
   logic [AW-1:0]   wa;
   logic [XLEN-1:0] wd;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign we = clr_busy_ff | wr_en;
   assign wa = clr_busy_ff ? clr_cnt_ff : wr_addr;
   assign wd = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = q_ff;
   assign busy    = clr_busy_ff;

endmodule

@@ rtl/toy_isa_instruction_executor.sv @@
// ============================================================================
// toy_isa_instruction_executor : small 32-bit ISA executor
// Runs one instruction word (or one data memory preload) per transaction
// against a register file and a data memory, returning one result each.
// ============================================================================
// Usage:
//  - req_* carries one transaction: tuser selects execute (0) or preload (1),
//    tdata holds the instruction word and the preload address and data.
//  - rsp_* returns exactly one result per request, in order.
//  - csr_wr_en/csr_wr_data write program_length; write only while idle.
//  - Path: an accepted request is held in the execute stage and its result is
//    then registered in the output register; a load adds a data phase.
//  - Throughput: one transaction per cycle unless the output stalls; a load
//    holds the execute stage for a data phase to read the data memory.
//    Register reads are registered; a write on the accept edge is forwarded.
//  - Reset: pc and all registers read as zero; the data memory is cleared
//    in a sweep over all MEM_WORDS words, during which req_tready stays low.
//  - When rsp_tready is low the result stays in the output register, the
//    execute stage holds its item and, while it holds one, req_tready is low.
// ============================================================================
module toy_isa_instruction_executor
   import tie_pkg::*;
#(
   parameter int MEM_WORDS = 1024
)
(
   input  logic                   clock,
   input  logic                   reset,
   // csr
   input  logic                   csr_wr_en,
   input  logic [LEN_W-1:0]       csr_wr_data,   // program_length
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] instr_word, [41:32] preload_addr, [73:42] preload_data, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,     // [0] op
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] next_pc, [32] done_res, [33] reg_written, [38:34] reg_index,
   // [70:39] reg_value, [71] mem_written, [81:72] mem_address,
   // [113:82] mem_value, [114] addr_error, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(MEM_WORDS);

   // ---------------- request decode for register read ----------------
   logic [XLEN-1:0]      in_instr;
   logic [OPC_W-1:0]     in_opc;
   logic [REG_IDX_W-1:0] in_idx_a, in_idx_b;
   logic                 accept;

   assign in_instr = req_tdata[31:0];
   assign in_opc   = in_instr[31:26];
   // port A: rs1, or rd for a store; port B: rs2, or rd for a branch
   assign in_idx_a = (in_opc == OPC_ST) ? in_instr[25:21] : in_instr[20:16];
   assign in_idx_b = is_branch(in_opc) ? in_instr[25:21] : in_instr[15:11];

   // ---------------- state ----------------
   logic [LEN_W-1:0]       prog_len_ff, prog_len_in;
   logic [XLEN-1:0]        pc_ff, pc_in;
   logic                   x_valid_ff, x_valid_in;
   logic                   x_phase_ff, x_phase_in;
   logic                   x_op_ff;
   logic [XLEN-1:0]        x_instr_ff;
   logic [MADDR_W-1:0]     x_paddr_ff;
   logic [XLEN-1:0]        x_pdata_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // ---------------- memories ----------------
   logic [XLEN-1:0] rf_a, rf_b;
   rf_wr_type       rf_wr;
   logic            dm_rd_en, dm_wr_en, dm_busy;
   logic [AW-1:0]   dm_wr_addr;
   logic [XLEN-1:0] dm_rdata, dm_wdata;

   tie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_idx_a  (in_idx_a),
      .rd_idx_b  (in_idx_b),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr        (rf_wr)
   );

   // ---------------- execute stage ----------------
   logic [OPC_W-1:0]     x_opc;
   logic [REG_IDX_W-1:0] x_rd, x_rs1, x_idx_a, x_idx_b;
   logic                 x_branch;
   logic [XLEN-1:0]      x_imm, pc_inc, pc_src, op_a, op_b, alu_b, alu_res;
   logic [XLEN:0]        ls_addr;
   logic                 ls_ok, pl_ok, take;
   logic [16:0]          pl_addr_ext;
   logic [AW-1:0]        ls_idx, pl_idx;
   logic                 need_wait, out_free, done_cyc;

   assign x_opc    = x_instr_ff[31:26];
   assign x_rd     = x_instr_ff[25:21];
   assign x_rs1    = x_instr_ff[20:16];
   assign x_idx_a  = (x_opc == OPC_ST) ? x_rd : x_rs1;
   assign x_idx_b  = is_branch(x_opc) ? x_rd : x_instr_ff[15:11];
   assign x_branch = is_branch(x_opc);
   assign x_imm    = {{16{x_instr_ff[15]}}, x_instr_ff[15:0]};

   // register 0 is the pc: branches see it before the increment, others after
   assign pc_inc = pc_ff + 1'b1;
   assign pc_src = x_branch ? pc_ff : pc_inc;
   assign op_a   = (x_idx_a == '0) ? pc_src : rf_a;
   assign op_b   = (x_idx_b == '0) ? pc_src : rf_b;

   assign alu_b   = (x_opc == OPC_ADDI) ? x_imm : op_b;
   assign alu_res = (x_opc == OPC_SUB) ? (op_a - alu_b) : (op_a + alu_b);

   assign ls_addr = {{(XLEN + 1 - REG_IDX_W){1'b0}}, x_rs1} + {op_b[XLEN-1], op_b};
   assign ls_ok   = !ls_addr[XLEN] && (ls_addr < (XLEN + 1)'(MEM_WORDS));
   assign ls_idx  = ls_addr[AW-1:0];

   assign pl_addr_ext = {{(17 - MADDR_W){1'b0}}, x_paddr_ff};
   assign pl_ok       = pl_addr_ext < 17'(MEM_WORDS);
   assign pl_idx      = pl_addr_ext[AW-1:0];

   always_comb begin
      unique case (x_opc)
         OPC_BNE: take = $signed(op_b) != $signed(op_a);
         OPC_BEQ: take = $signed(op_b) == $signed(op_a);
         OPC_BGT: take = $signed(op_b) >  $signed(op_a);
         OPC_BGE: take = $signed(op_b) >= $signed(op_a);
         default: take = 1'b0;
      endcase
   end

   assign need_wait = (x_op_ff == OP_EXEC) && (x_opc == OPC_LD) && !x_phase_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign done_cyc  = x_valid_ff && !need_wait && out_free;
   assign accept    = req_tvalid && req_tready;
   assign req_tready = !dm_busy && (!x_valid_ff || done_cyc);

   // result of the item in the execute stage
   logic [XLEN-1:0]      pc_new, rval, mval;
   logic [REG_IDX_W-1:0] ridx;
   logic [MADDR_W-1:0]   maddr;
   logic                 rw, mw, aerr, done_flag;

   always_comb begin
      pc_new = pc_ff;
      rw     = 1'b0;
      ridx   = '0;
      rval   = '0;
      mw     = 1'b0;
      maddr  = '0;
      mval   = '0;
      aerr   = 1'b0;
      if (x_op_ff == OP_PRELOAD) begin
         maddr = x_paddr_ff;
         if (pl_ok) begin
            mw   = 1'b1;
            mval = x_pdata_ff;
         end else begin
            aerr = 1'b1;
         end
      end else begin
         unique case (x_opc)
            OPC_BNE, OPC_BEQ, OPC_BGT, OPC_BGE: begin
               pc_new = take ? (pc_ff + x_imm) : pc_inc;
            end
            OPC_JMP: begin
               pc_new = pc_ff + x_imm;
            end
            OPC_ADD, OPC_SUB, OPC_ADDI: begin
               pc_new = pc_inc;
               rw     = 1'b1;
               ridx   = x_rd;
               rval   = alu_res;
            end
            OPC_LD, OPC_ST: begin
               pc_new = pc_inc;
               maddr  = ls_addr[MADDR_W-1:0];
               if (!ls_ok) begin
                  aerr = 1'b1;
               end else if (x_opc == OPC_LD) begin
                  mval = dm_rdata;
                  rw   = 1'b1;
                  ridx = x_rd;
                  rval = dm_rdata;
               end else begin
                  mval = op_a;
                  mw   = 1'b1;
               end
            end
            default: begin
               pc_new = pc_inc;
            end
         endcase
         // destination write comes last: register 0 replaces the pc
         if (rw && (ridx == '0)) begin
            pc_new = rval;
         end
      end
   end

   assign done_flag = $signed({pc_new[XLEN-1], pc_new}) >=
                      $signed({{(XLEN + 1 - LEN_W){1'b0}}, prog_len_ff});

   // ---------------- memory access ----------------
   assign rf_wr.en   = done_cyc && rw && (ridx != '0);
   assign rf_wr.idx  = ridx;
   assign rf_wr.data = rval;

   assign dm_rd_en   = x_valid_ff && need_wait && ls_ok;
   assign dm_wr_en   = done_cyc && mw;
   assign dm_wr_addr = (x_op_ff == OP_PRELOAD) ? pl_idx : ls_idx;
   assign dm_wdata   = mval;

   tie_dmem #(
      .MEM_WORDS (MEM_WORDS),
      .AW        (AW)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (dm_rd_en),
      .rd_addr (ls_idx),
      .rd_data (dm_rdata),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wdata),
      .busy    (dm_busy)
   );

   // ---------------- registers ----------------
   assign prog_len_in  = csr_wr_en ? csr_wr_data : prog_len_ff;
   assign pc_in        = (done_cyc && (x_op_ff == OP_EXEC)) ? pc_new : pc_ff;
   assign x_valid_in   = accept ? 1'b1 : (done_cyc ? 1'b0 : x_valid_ff);
   assign x_phase_in   = accept ? 1'b0 : ((x_valid_ff && need_wait) ? 1'b1 : x_phase_ff);
   assign rsp_valid_in = done_cyc ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff  <= '0;
         pc_ff        <= '0;
         x_valid_ff   <= 1'b0;
         x_phase_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prog_len_ff  <= prog_len_in;
         pc_ff        <= pc_in;
         x_valid_ff   <= x_valid_in;
         x_phase_ff   <= x_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_op_ff    <= req_tuser;
         x_instr_ff <= in_instr;
         x_paddr_ff <= req_tdata[41:32];
         x_pdata_ff <= req_tdata[73:42];
      end
      if (done_cyc) begin
         rsp_data_ff <= {5'b0, aerr, mval, maddr, mw, rval, ridx, rw, done_flag, pc_new};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      dm_busy |-> !req_tready)
      else $error("request taken during data memory clearing");

   a_load_two_phase: assert property (@(posedge clock) disable iff (reset)
      (x_valid_ff && need_wait) |=> (x_valid_ff && x_phase_ff))
      else $error("load left execute stage without its data phase");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      done_cyc |=> rsp_valid_ff)
      else $error("completed transaction produced no result");

   a_preload_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (done_cyc && (x_op_ff == OP_PRELOAD)) |=> $stable(pc_ff))
      else $error("preload changed the pc");

endmodule
